// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. They compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// prop must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg)

`endif

`endif

// ===== sv/fse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fse_pkg
// Shared types and constants of the flight state estimator.
// ----------------------------------------------------------------------------
package fse_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int NOISE_W       = 20;
  localparam int ACC_W         = 16;
  localparam int MS_W          = 16;
  localparam int CFG_IDX_W     = 2;

  // velocity product magnitude: |accel| (32 bits) times elapsed ms (16 bits)
  localparam int PROD_W        = DATA_W + MS_W;
  localparam int MS_PER_S      = 1000;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = CFG_IDX_W'(1);

  localparam logic [NOISE_W-1:0] PROC_NOISE_RST = NOISE_W'(6554);
  localparam logic [NOISE_W-1:0] MEAS_NOISE_RST = NOISE_W'(13107);

  typedef struct packed {
    logic signed [DATA_W-1:0] altitude_sample;
    logic signed [ACC_W-1:0]  acc_sample;
    logic [MS_W-1:0]          elapsed_ms;
    logic                     zero_velocity;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] smooth_altitude;
    logic signed [DATA_W-1:0] smooth_accel;
    logic signed [DATA_W-1:0] speed_estimate;
    logic signed [DATA_W-1:0] peak_altitude;
  } out_item_t;

  // filter status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } kf_stat_t;

  // width of a measurement: altitude, or acceleration scaled by 2^frac
  function automatic int z_width(int frac);
    return (ACC_W + frac > DATA_W) ? ACC_W + frac : DATA_W;
  endfunction

endpackage

// ===== sv/fse_kalman.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fse_kalman
// One scalar Kalman filter: bit-serial gain division, then bit-serial
// estimate and covariance updates, one gain bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fse_kalman #(
  parameter int  FRAC_BITS = fse_pkg::FRAC_BITS_DEF,
  localparam int ZW        = fse_pkg::z_width(FRAC_BITS)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ZW-1:0]              z_i,
  input  logic [fse_pkg::NOISE_W-1:0]       proc_noise_i,
  input  logic [fse_pkg::NOISE_W-1:0]       meas_noise_i,
  output logic signed [fse_pkg::DATA_W-1:0] est_o,
  output fse_pkg::kf_stat_t                 stat_o
);

  localparam int DW  = fse_pkg::DATA_W;
  localparam int KW  = FRAC_BITS + 1;
  localparam int YW  = ZW + 1;
  localparam int AXW = YW + KW;
  localparam int APW = DW + KW;
  localparam int EW  = AXW - FRAC_BITS + 1;
  localparam int SW  = DW + 1;
  localparam int RW  = DW + 2;
  localparam int CW  = $clog2(KW);

  localparam logic [KW-1:0] KOne  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CW-1:0] CntLast = CW'(KW - 1);

  typedef enum logic [3:0] {
    KF_IDLE = 4'b0001,
    KF_DIV  = 4'b0010,
    KF_MUL  = 4'b0100,
    KF_FIN  = 4'b1000
  } kf_state_e;

  kf_state_e state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic signed [DW-1:0]  est_q, est_d;
  logic [DW-1:0]         cov_q, cov_d;
  logic [DW-1:0]         p_q, p_d;
  logic [SW-1:0]         s_q, s_d;
  logic [RW-1:0]         rem_q, rem_d;
  logic signed [YW-1:0]  y_q, y_d;
  logic [KW-1:0]         k_q, k_d;
  logic [KW-1:0]         mc_q, mc_d;
  logic signed [AXW-1:0] accx_q, accx_d;
  logic [APW-1:0]        accp_q, accp_d;

  logic [SW-1:0]        p_sum;
  logic [DW-1:0]        p_sat;
  logic [SW-1:0]        s_sum;
  logic                 q_bit;
  logic [RW-1:0]        rem_sub;
  logic [KW-1:0]        k_next;
  logic signed [EW-1:0] x_sum;
  logic signed [DW-1:0] x_sat;

  always_comb begin
    p_sum   = {1'b0, cov_q} + SW'(proc_noise_i);
    p_sat   = p_sum[DW] ? '1 : p_sum[DW-1:0];
    s_sum   = {1'b0, p_sat} + SW'(meas_noise_i);
    // zero innovation covariance gives zero gain
    q_bit   = (rem_q >= RW'(s_q)) && (s_q != '0);
    rem_sub = q_bit ? rem_q - RW'(s_q) : rem_q;
    k_next  = {k_q[KW-2:0], q_bit};
    x_sum   = EW'(est_q) + EW'(accx_q >>> FRAC_BITS);
    if ((&x_sum[EW-1:DW-1]) || !(|x_sum[EW-1:DW-1])) begin
      x_sat = x_sum[DW-1:0];
    end else begin
      x_sat = x_sum[EW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    est_d   = est_q;
    cov_d   = cov_q;
    p_d     = p_q;
    s_d     = s_q;
    rem_d   = rem_q;
    y_d     = y_q;
    k_d     = k_q;
    mc_d    = mc_q;
    accx_d  = accx_q;
    accp_d  = accp_q;
    case (state_q)
      KF_IDLE: begin
        if (start_i) begin
          p_d     = p_sat;
          s_d     = s_sum;
          rem_d   = RW'(p_sat);
          y_d     = YW'(z_i) - YW'(est_q);
          cnt_d   = '0;
          state_d = KF_DIV;
        end
      end
      KF_DIV: begin
        rem_d = {rem_sub[RW-2:0], 1'b0};
        k_d   = k_next;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CntLast) begin
          cnt_d   = '0;
          mc_d    = KOne - k_next;
          accx_d  = '0;
          accp_d  = '0;
          state_d = KF_MUL;
        end
      end
      KF_MUL: begin
        // MSB-first shift-add over the gain bits
        accx_d = (accx_q <<< 1) + (k_q[KW-1] ? AXW'(y_q) : AXW'(0));
        accp_d = (accp_q << 1) + (mc_q[KW-1] ? APW'(p_q) : APW'(0));
        k_d    = k_q << 1;
        mc_d   = mc_q << 1;
        cnt_d  = cnt_q + CW'(1);
        if (cnt_q == CntLast) begin
          state_d = KF_FIN;
        end
      end
      KF_FIN: begin
        est_d   = x_sat;
        cov_d   = accp_q[FRAC_BITS +: DW];
        state_d = KF_IDLE;
      end
      default: begin
        state_d = KF_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KF_IDLE;
      cnt_q   <= '0;
      est_q   <= '0;
      cov_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      est_q   <= est_d;
      cov_q   <= cov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    s_q    <= s_d;
    rem_q  <= rem_d;
    y_q    <= y_d;
    k_q    <= k_d;
    mc_q   <= mc_d;
    accx_q <= accx_d;
    accp_q <= accp_d;
  end

  assign est_o       = est_q;
  assign stat_o.busy = (state_q != KF_IDLE);
  assign stat_o.done = (state_q == KF_FIN);

  `ASSERT_PROP(a_gain_in_range, clk_i, rst_ni,
               ((state_q == KF_MUL) && (cnt_q == '0)) |->
               ((k_q <= KOne) && (KW'(k_q + mc_q) == KOne)),
               "gain out of range")
  `ASSERT_NEVER(a_start_while_busy, clk_i, rst_ni, start_i && (state_q != KF_IDLE),
                "filter started while busy")
  `ASSERT_PROP(a_state_onehot, clk_i, rst_ni, $onehot(state_q), "filter state not one-hot")

endmodule

// ===== sv/flight_state_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flight_state_estimator
// Altitude and acceleration Kalman filters, velocity integration and peak
// altitude tracking in signed fixed point.
// ----------------------------------------------------------------------------
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+---------------------------
// in       | input     | in_valid_i / in_stall_o   | fse_pkg::in_item_t
// out      | output    | out_valid_o / out_stall_i | fse_pkg::out_item_t
// cfg      | input     | cfg_we_i (no wait)        | cfg_index_i, cfg_data_i
//
// Per item, both filters run the gain division and update multiply and close;
// then come a velocity multiply over the 16 bits of elapsed ms, a division by
// 1000 for 48 quotient bits, the load of the result and the return to idle.
// Reset clears the filter estimates and covariances, velocity and peak and loads the noise defaults.
// A new item is taken while a finished result waits in the output register;
// a stalled output holds the next result in the final state, ST_FIN.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flight_state_estimator #(
  parameter int FRAC_BITS = fse_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  fse_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output fse_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [fse_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fse_pkg::NOISE_W-1:0]         cfg_data_i
);

  localparam int ZW    = fse_pkg::z_width(FRAC_BITS);
  localparam int DW    = fse_pkg::DATA_W;
  localparam int MW    = fse_pkg::MS_W;
  localparam int PW    = fse_pkg::PROD_W;
  localparam int SUMW  = PW + 1;
  localparam int REMW  = $clog2(fse_pkg::MS_PER_S);
  localparam int CNTW  = $clog2(PW);

  localparam logic [REMW:0]   Divisor  = (REMW + 1)'(fse_pkg::MS_PER_S);
  localparam logic [CNTW-1:0] MulLast  = CNTW'(MW - 1);
  localparam logic [CNTW-1:0] DivLast  = CNTW'(PW - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_FILT = 5'b00010,
    ST_VMUL = 5'b00100,
    ST_VDIV = 5'b01000,
    ST_FIN  = 5'b10000
  } fse_state_e;

  fse_state_e state_q, state_d;
  logic [CNTW-1:0]              cnt_q, cnt_d;
  logic [fse_pkg::NOISE_W-1:0]  q_q, q_d;
  logic [fse_pkg::NOISE_W-1:0]  r_q, r_d;
  logic signed [DW-1:0]         speed_q, speed_d;
  logic signed [DW-1:0]         peak_q, peak_d;
  logic                         out_valid_q, out_valid_d;
  fse_pkg::out_item_t           out_data_q, out_data_d;
  logic [MW-1:0]                ms_q, ms_d;
  logic                         clear_q, clear_d;
  logic [PW-1:0]                prod_q, prod_d;
  logic [REMW-1:0]              rem_q, rem_d;

  logic                   start;
  logic signed [ZW-1:0]   alt_z, acc_z;
  logic signed [DW-1:0]   alt_est, acc_est;
  fse_pkg::kf_stat_t      alt_stat, acc_stat;

  logic                   acc_neg;
  logic [DW-1:0]          acc_mag;
  logic [REMW:0]          rem_ext;
  logic                   rem_ge;
  logic signed [SUMW-1:0] dv;
  logic signed [SUMW-1:0] speed_base;
  logic signed [SUMW-1:0] speed_sum;
  logic signed [DW-1:0]   speed_sat;
  logic signed [DW-1:0]   peak_new;

  assign start = in_valid_i && !in_stall_o;
  assign alt_z = ZW'($signed(in_data_i.altitude_sample));
  assign acc_z = ZW'($signed(in_data_i.acc_sample)) <<< FRAC_BITS;

  fse_kalman #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alt_kf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .z_i         (alt_z),
    .proc_noise_i(q_q),
    .meas_noise_i(r_q),
    .est_o       (alt_est),
    .stat_o      (alt_stat)
  );

  fse_kalman #(
    .FRAC_BITS(FRAC_BITS)
  ) u_acc_kf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .z_i         (acc_z),
    .proc_noise_i(q_q),
    .meas_noise_i(r_q),
    .est_o       (acc_est),
    .stat_o      (acc_stat)
  );

  always_comb begin
    acc_neg    = acc_est[DW-1];
    acc_mag    = acc_neg ? DW'(-acc_est) : DW'(acc_est);
    rem_ext    = {rem_q, prod_q[PW-1]};
    rem_ge     = (rem_ext >= Divisor);
    // quotient magnitude sits in prod_q after the division; truncation is toward zero
    dv         = acc_neg ? -SUMW'(prod_q) : SUMW'(prod_q);
    speed_base = clear_q ? SUMW'(0) : SUMW'(speed_q);
    speed_sum  = speed_base + dv;
    if ((&speed_sum[SUMW-1:DW-1]) || !(|speed_sum[SUMW-1:DW-1])) begin
      speed_sat = speed_sum[DW-1:0];
    end else begin
      speed_sat = speed_sum[SUMW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    peak_new = (alt_est > peak_q) ? alt_est : peak_q;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    q_d         = q_q;
    r_d         = r_q;
    speed_d     = speed_q;
    peak_d      = peak_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    ms_d        = ms_q;
    clear_d     = clear_q;
    prod_d      = prod_q;
    rem_d       = rem_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        fse_pkg::REG_PROCESS_NOISE: q_d = cfg_data_i;
        fse_pkg::REG_MEASURE_NOISE: r_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          ms_d    = in_data_i.elapsed_ms;
          clear_d = in_data_i.zero_velocity;
          state_d = ST_FILT;
        end
      end
      ST_FILT: begin
        if (acc_stat.done) begin
          prod_d  = '0;
          cnt_d   = '0;
          state_d = ST_VMUL;
        end
      end
      ST_VMUL: begin
        prod_d = (prod_q << 1) + (ms_q[MW-1] ? PW'(acc_mag) : PW'(0));
        ms_d   = ms_q << 1;
        cnt_d  = cnt_q + CNTW'(1);
        if (cnt_q == MulLast) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = ST_VDIV;
        end
      end
      ST_VDIV: begin
        rem_d  = rem_ge ? REMW'(rem_ext - Divisor) : REMW'(rem_ext);
        prod_d = {prod_q[PW-2:0], rem_ge};
        cnt_d  = cnt_q + CNTW'(1);
        if (cnt_q == DivLast) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d                = 1'b1;
          out_data_d.smooth_altitude = alt_est;
          out_data_d.smooth_accel    = acc_est;
          out_data_d.speed_estimate  = speed_sat;
          out_data_d.peak_altitude   = peak_new;
          speed_d                    = speed_sat;
          peak_d                     = peak_new;
          state_d                    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      q_q         <= fse_pkg::PROC_NOISE_RST;
      r_q         <= fse_pkg::MEAS_NOISE_RST;
      speed_q     <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      q_q         <= q_d;
      r_q         <= r_d;
      speed_q     <= speed_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    ms_q       <= ms_d;
    clear_q    <= clear_d;
    prod_q     <= prod_d;
    rem_q      <= rem_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_PROP(a_filters_lockstep, clk_i, rst_ni, alt_stat.done == acc_stat.done,
               "filters out of step")
  `ASSERT_PROP(a_done_in_filt, clk_i, rst_ni, acc_stat.done |-> (state_q == ST_FILT),
               "filter done outside filter phase")
  `ASSERT_PROP(a_accept_filters_idle, clk_i, rst_ni,
               start |-> !(alt_stat.busy || acc_stat.busy),
               "transfer accepted while filters busy")
  `ASSERT_PROP(a_peak_monotonic, clk_i, rst_ni, peak_q >= $past(peak_q),
               "peak altitude decreased")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the flight state estimator. Each sample the block
// takes is run through a local fixed-point model of both Kalman filters, the
// velocity integrator and the peak tracker. Every result is then compared
// with the oldest predicted estimate. A short directed run covers field
// extremes, zero noise, unity gain, ignored register writes and a negative
// altitude run with the peak held at zero. Random phases follow, each with
// new noise settings, bursty input and a stalling output side.
// ----------------------------------------------------------------------------

class estimate_tracker;

  localparam int FRAC = fse_pkg::FRAC_BITS_DEF;
  localparam int DW   = fse_pkg::DATA_W;

  logic [fse_pkg::NOISE_W-1:0] proc_noise;
  logic [fse_pkg::NOISE_W-1:0] meas_noise;
  logic signed [DW-1:0]        alt_est;
  logic [DW-1:0]               alt_cov;
  logic signed [DW-1:0]        acc_est;
  logic [DW-1:0]               acc_cov;
  logic signed [DW-1:0]        speed;
  logic signed [DW-1:0]        peak;
  fse_pkg::out_item_t          pending_estimates[$];
  int unsigned                 mismatches;

  function new();
    proc_noise = fse_pkg::PROC_NOISE_RST;
    meas_noise = fse_pkg::MEAS_NOISE_RST;
    alt_est    = '0;
    alt_cov    = '0;
    acc_est    = '0;
    acc_cov    = '0;
    speed      = '0;
    peak       = '0;
    mismatches = 0;
  endfunction

  function void set_noise(logic [fse_pkg::CFG_IDX_W-1:0] idx,
                          logic [fse_pkg::NOISE_W-1:0] val);
    case (idx)
      fse_pkg::REG_PROCESS_NOISE: proc_noise = val;
      fse_pkg::REG_MEASURE_NOISE: meas_noise = val;
      default: ;
    endcase
  endfunction

  function longint clamp32(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
    if (v < -longint'(64'h8000_0000)) return -longint'(64'h8000_0000);
    return v;
  endfunction

  function logic signed [DW-1:0] kalman_update(input longint meas,
                                               inout logic signed [DW-1:0] est,
                                               inout logic [DW-1:0] cov);
    longint unsigned unity;
    longint unsigned p_pred;
    longint unsigned innov;
    longint unsigned gain;
    longint          resid;
    longint          upd;
    unity  = 64'd1 << FRAC;
    p_pred = 64'(cov) + 64'(proc_noise);
    if (p_pred > 64'hFFFF_FFFF) p_pred = 64'hFFFF_FFFF;
    innov  = p_pred + 64'(meas_noise);
    gain   = (innov == 0) ? 64'd0 : (p_pred << FRAC) / innov;
    if (gain > unity) gain = unity;
    resid  = meas - longint'(est);
    upd    = longint'(gain) * resid;
    est    = DW'(clamp32(longint'(est) + (upd >>> FRAC)));
    cov    = DW'(((unity - gain) * p_pred) >> FRAC);
    return est;
  endfunction

  function void take_sample(fse_pkg::in_item_t it);
    logic signed [DW-1:0] alt;
    logic signed [DW-1:0] acc;
    longint               dv;
    fse_pkg::out_item_t   res;
    alt = kalman_update(longint'($signed(it.altitude_sample)), alt_est, alt_cov);
    acc = kalman_update(longint'($signed(it.acc_sample)) * (longint'(1) << FRAC),
                        acc_est, acc_cov);
    if (it.zero_velocity) speed = '0;
    dv    = (longint'(acc) * longint'(it.elapsed_ms)) / fse_pkg::MS_PER_S;
    speed = DW'(clamp32(longint'(speed) + dv));
    if (alt > peak) peak = alt;
    res.smooth_altitude = alt;
    res.smooth_accel    = acc;
    res.speed_estimate  = speed;
    res.peak_altitude   = peak;
    pending_estimates.push_back(res);
  endfunction

  function void match_estimate(fse_pkg::out_item_t got);
    fse_pkg::out_item_t want;
    if (pending_estimates.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected transfer: alt %h accel %h speed %h peak %h",
                 got.smooth_altitude, got.smooth_accel, got.speed_estimate,
                 got.peak_altitude);
      return;
    end
    want = pending_estimates.pop_front();
    if (got.smooth_altitude !== want.smooth_altitude ||
        got.smooth_accel !== want.smooth_accel ||
        got.speed_estimate !== want.speed_estimate ||
        got.peak_altitude !== want.peak_altitude) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch (exp/got): alt %h/%h accel %h/%h speed %h/%h peak %h/%h",
                 want.smooth_altitude, got.smooth_altitude,
                 want.smooth_accel, got.smooth_accel,
                 want.speed_estimate, got.speed_estimate,
                 want.peak_altitude, got.peak_altitude);
    end
  endfunction

  function int outstanding();
    return pending_estimates.size();
  endfunction

endclass

module testbench;

  localparam int DATA_W    = fse_pkg::DATA_W;
  localparam int ACC_W     = fse_pkg::ACC_W;
  localparam int MS_W      = fse_pkg::MS_W;
  localparam int NOISE_W   = fse_pkg::NOISE_W;
  localparam int CFG_IDX_W = fse_pkg::CFG_IDX_W;

  localparam int CLK_HALF       = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * fse_pkg::FRAC_BITS_DEF + 69 + 40;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_SAMPLES  = 166;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = CFG_IDX_W'(3);
  localparam logic [NOISE_W-1:0]   NOISE_MAX       = '1;
  localparam logic signed [DATA_W-1:0] ALT_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] ALT_MIN     = 32'sh8000_0000;
  localparam logic signed [ACC_W-1:0]  ACC_MAX     = 16'sh7FFF;
  localparam logic signed [ACC_W-1:0]  ACC_MIN     = 16'sh8000;
  localparam logic [MS_W-1:0]          MS_MAX      = '1;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  fse_pkg::in_item_t    in_data_i   = '0;
  logic                 out_stall_i = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [NOISE_W-1:0]   cfg_data_i  = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  fse_pkg::out_item_t   out_data_o;

  estimate_tracker board = new();

  int     burst_left = 0;
  int     stall_left = 0;
  logic   stall_next = 1'b0;
  int     idle_cycles = 0;
  longint track_alt = 0;
  longint climb = 0;

  flight_state_estimator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.take_sample(in_data_i);
      if (out_valid_o && !out_stall_i) board.match_estimate(out_data_o);
    end
  end

  // receiver: stall runs, short bursts and long clear stretches
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 5))
        0: begin
          stall_next = 1'b0;
          stall_left = $urandom_range(100, 600);
        end
        1, 2: begin
          stall_next = 1'b1;
          stall_left = $urandom_range(1, 40);
        end
        3: begin
          stall_next = 1'b1;
          stall_left = $urandom_range(1, 4);
        end
        default: begin
          stall_next = 1'b0;
          stall_left = $urandom_range(1, 30);
        end
      endcase
    end
    stall_left--;
    out_stall_i <= stall_next;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) ||
        (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("flight_state_estimator test failed");
      $finish;
    end
  end

  function automatic fse_pkg::in_item_t sample_of(logic signed [DATA_W-1:0] alt,
                                                  logic signed [ACC_W-1:0] acc,
                                                  logic [MS_W-1:0] ms, logic zv);
    fse_pkg::in_item_t it;
    it.altitude_sample = alt;
    it.acc_sample      = acc;
    it.elapsed_ms      = ms;
    it.zero_velocity   = zv;
    return it;
  endfunction

  // mostly a plausible flight track, some fully random samples
  function automatic fse_pkg::in_item_t random_sample();
    fse_pkg::in_item_t it;
    if ($urandom_range(0, 9) < 3) begin
      it.altitude_sample = $urandom;
      it.acc_sample      = ACC_W'($urandom);
      it.elapsed_ms      = MS_W'($urandom);
      it.zero_velocity   = 1'($urandom_range(0, 1));
    end else begin
      climb = climb + longint'($urandom_range(0, 131072)) - 65536;
      if (climb > 4194304 || climb < -4194304) climb = 0;
      track_alt = track_alt + climb;
      if (track_alt > 1073741824 || track_alt < -536870912) begin
        track_alt = 0;
        climb     = 0;
      end
      it.altitude_sample = DATA_W'(track_alt + longint'($urandom_range(0, 131072)) - 65536);
      it.acc_sample      = ACC_W'(int'($urandom_range(0, 600)) - 300);
      it.elapsed_ms      = MS_W'($urandom_range(5, 100));
      it.zero_velocity   = ($urandom_range(0, 31) == 0);
    end
    return it;
  endfunction

  task automatic send_sample(fse_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 160);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  // let the clock edge pass first so the last accepted sample is already noted
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic program_noise(logic [CFG_IDX_W-1:0] idx, logic [NOISE_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    board.set_noise(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic retune_noise();
    logic [NOISE_W-1:0] pn;
    logic [NOISE_W-1:0] mn;
    case ($urandom_range(0, 4))
      0: pn = '0;
      1: pn = NOISE_MAX;
      2: pn = fse_pkg::PROC_NOISE_RST;
      default: pn = NOISE_W'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: mn = '0;
      1: mn = NOISE_W'(1);
      2: mn = NOISE_MAX;
      default: mn = NOISE_W'($urandom);
    endcase
    program_noise(fse_pkg::REG_PROCESS_NOISE, pn);
    program_noise(fse_pkg::REG_MEASURE_NOISE, mn);
    if ($urandom_range(0, 2) == 0)
      program_noise($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                    NOISE_W'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset noise; negative altitudes keep the peak at zero
    send_sample(sample_of(-32'sd1, 16'sd0, 16'd0, 1'b0));
    send_sample(sample_of(ALT_MIN, ACC_MAX, MS_MAX, 1'b0));
    send_sample(sample_of(ALT_MIN, ACC_MAX, MS_MAX, 1'b0));
    send_sample(sample_of(-32'sd65536, ACC_MIN, MS_MAX, 1'b0));
    send_sample(sample_of(-32'sd65536, ACC_MIN, MS_MAX, 1'b0));
    send_sample(sample_of(-32'sd100, 16'sd0, 16'd1000, 1'b1));
    send_sample(sample_of(ALT_MAX, 16'sd0, 16'd0, 1'b0));
    send_sample(sample_of(32'sd0, 16'sd1, 16'd1, 1'b0));
    send_sample(sample_of(ALT_MIN, -16'sd1, MS_MAX, 1'b1));

    // zero noise: unity gain once, then zero covariance holds the estimate
    settle();
    program_noise(fse_pkg::REG_PROCESS_NOISE, '0);
    program_noise(fse_pkg::REG_MEASURE_NOISE, '0);
    program_noise(REG_UNMAPPED_LO, NOISE_MAX);
    program_noise(REG_UNMAPPED_HI, NOISE_MAX);
    send_sample(sample_of(32'sd65536000, 16'sd100, 16'd50, 1'b0));
    send_sample(sample_of(-32'sd327680, -16'sd100, 16'd50, 1'b0));
    send_sample(sample_of(ALT_MAX, ACC_MAX, MS_MAX, 1'b0));

    // measurement noise zero: gain of one
    settle();
    program_noise(fse_pkg::REG_PROCESS_NOISE, NOISE_MAX);
    send_sample(sample_of(32'sd123456789, ACC_MIN, 16'd20, 1'b0));
    send_sample(sample_of(-32'sd987654321, ACC_MAX, 16'd20, 1'b1));

    settle();
    program_noise(fse_pkg::REG_MEASURE_NOISE, NOISE_MAX);
    send_sample(sample_of(ALT_MAX, ACC_MAX, MS_MAX, 1'b0));
    send_sample(sample_of(ALT_MIN, ACC_MIN, MS_MAX, 1'b0));
    send_sample(sample_of(32'sd0, 16'sd0, 16'd10, 1'b1));

    settle();
    program_noise(fse_pkg::REG_PROCESS_NOISE, '0);
    program_noise(fse_pkg::REG_MEASURE_NOISE, NOISE_W'(1));
    send_sample(sample_of(32'sd655360, 16'sd9, 16'd100, 1'b0));
    send_sample(sample_of(32'sd655360, 16'sd9, 16'd100, 1'b0));

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      retune_noise();
      repeat (PHASE_SAMPLES) send_sample(random_sample());
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.outstanding() == 0)
      $display("flight_state_estimator test passed");
    else
      $display("flight_state_estimator test failed");
    $finish;
  end

endmodule
